[sv/scan_point_projection_top_assert.svh]
// Assertion macros for the scan point projection block.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef SCAN_POINT_PROJECTION_TOP_ASSERT_SVH
`define SCAN_POINT_PROJECTION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold after the antecedent, with the delay given by n.
`define SPP_ASSERT_DELAY(lbl, ante, n, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

[sv/spp_pkg.sv]
// Shared constants, types and the arctangent table of the scan point projection.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package spp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int MAX_STAGES    = 24;
   localparam int CORDIC_RUN    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   // Datapath widths: x/y carry range * gain in Q30 with CORDIC growth headroom.
   localparam int XW   = 48;
   localparam int ZW   = 32;
   localparam int FRAC = 30;
   localparam int RW   = XW - FRAC;
   localparam int SW   = 34;

   // Cycles from an accepted beat to its result strobe.
   localparam int LATENCY = CORDIC_RUN + 3;

   localparam logic signed [XW-1:0] INV_GAIN   = XW'(64'sd652032875);
   localparam logic signed [XW-1:0] ROUND_HALF = XW'(64'sd1) <<< (FRAC - 1);

   localparam logic [15:0] QUARTER_TURN       = 16'h4000;
   localparam logic [15:0] THREE_QUARTER_TURN = 16'hC000;

   localparam int AW = 5;
   localparam logic [2:0] REG_POSE_X        = 3'd0;
   localparam logic [2:0] REG_POSE_Y        = 3'd1;
   localparam logic [2:0] REG_POSE_HEADING  = 3'd2;
   localparam logic [2:0] REG_RANGE_FLOOR   = 3'd3;
   localparam logic [2:0] REG_RANGE_CEILING = 3'd4;

   typedef struct packed {
      logic valid;
      logic kept;
      logic done;
   } spp_ctl_type;

   // atan(2^-idx) in units of 2^32 counts per turn.
   function automatic logic signed [ZW-1:0] spp_atan(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:  val = 32'sh20000000;
         1:  val = 32'sh12E4051E;
         2:  val = 32'sh09FB385B;
         3:  val = 32'sh051111D4;
         4:  val = 32'sh028B0D43;
         5:  val = 32'sh0145D7E1;
         6:  val = 32'sh00A2F61E;
         7:  val = 32'sh00517C55;
         8:  val = 32'sh0028BE53;
         9:  val = 32'sh00145F2F;
         10: val = 32'sh000A2F98;
         11: val = 32'sh000517CC;
         12: val = 32'sh00028BE6;
         13: val = 32'sh000145F3;
         14: val = 32'sh0000A2FA;
         15: val = 32'sh0000517D;
         16: val = 32'sh000028BE;
         17: val = 32'sh0000145F;
         18: val = 32'sh00000A30;
         19: val = 32'sh00000518;
         20: val = 32'sh0000028C;
         21: val = 32'sh00000146;
         22: val = 32'sh000000A3;
         23: val = 32'sh00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[sv/spp_csr.sv]
// Configuration registers of the scan point projection, behind an APB-style port.
// Depends on spp_pkg for register indexes and the address width.
`timescale 1ns / 1ps

module spp_csr import spp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [AW-1:0]      paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output logic signed [31:0] pose_x,
   output logic signed [31:0] pose_y,
   output logic [15:0]        pose_heading,
   output logic [15:0]        range_floor,
   output logic [15:0]        range_ceiling
);

   logic signed [31:0] pose_x_ff, pose_x_in;
   logic signed [31:0] pose_y_ff, pose_y_in;
   logic [15:0]        heading_ff, heading_in;
   logic [15:0]        floor_ff, floor_in;
   logic [15:0]        ceiling_ff, ceiling_in;
   logic               wr_en;
   logic [2:0]         index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[AW-1:2];

   always_comb begin
      pose_x_in  = pose_x_ff;
      pose_y_in  = pose_y_ff;
      heading_in = heading_ff;
      floor_in   = floor_ff;
      ceiling_in = ceiling_ff;
      if (wr_en) begin
         unique case (index)
            REG_POSE_X:        pose_x_in  = $signed(pwdata);
            REG_POSE_Y:        pose_y_in  = $signed(pwdata);
            REG_POSE_HEADING:  heading_in = pwdata[15:0];
            REG_RANGE_FLOOR:   floor_in   = pwdata[15:0];
            REG_RANGE_CEILING: ceiling_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
         floor_ff   <= '0;
         ceiling_ff <= 16'hFFFF;
      end else begin
         pose_x_ff  <= pose_x_in;
         pose_y_ff  <= pose_y_in;
         heading_ff <= heading_in;
         floor_ff   <= floor_in;
         ceiling_ff <= ceiling_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_POSE_X:        prdata = pose_x_ff;
         REG_POSE_Y:        prdata = pose_y_ff;
         REG_POSE_HEADING:  prdata = {16'h0, heading_ff};
         REG_RANGE_FLOOR:   prdata = {16'h0, floor_ff};
         REG_RANGE_CEILING: prdata = {16'h0, ceiling_ff};
         default:           prdata = '0;
      endcase
   end

   assign pose_x        = pose_x_ff;
   assign pose_y        = pose_y_ff;
   assign pose_heading  = heading_ff;
   assign range_floor   = floor_ff;
   assign range_ceiling = ceiling_ff;

endmodule

[sv/spp_front.sv]
// Front stage: range window check, angle sum with quadrant fold, and start vector.
// Depends on spp_pkg for widths, the inverse gain and the control struct.
`timescale 1ns / 1ps

module spp_front import spp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [15:0]          beam_range,
   input  logic [15:0]          beam_angle,
   input  logic                 scan_end,
   input  logic [15:0]          pose_heading,
   input  logic [15:0]          range_floor,
   input  logic [15:0]          range_ceiling,
   output spp_ctl_type          ctl_o,
   output logic signed [XW-1:0] x_o,
   output logic signed [ZW-1:0] z_o
);

   spp_ctl_type          ctl_ff, ctl_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [15:0]          angle_sum;
   logic                 fold;
   logic signed [16:0]   range_s;
   logic signed [XW-1:0] range_w;

   assign angle_sum = beam_angle + pose_heading;
   // Beyond a quarter turn either way: negate the start vector, remove a half turn.
   assign fold = (angle_sum > QUARTER_TURN) && (angle_sum < THREE_QUARTER_TURN);

   assign range_s = fold ? -$signed({1'b0, beam_range}) : $signed({1'b0, beam_range});
   assign range_w = XW'(range_s);

   assign x_in = range_w * INV_GAIN;
   assign z_in = $signed({angle_sum[15] ^ fold, angle_sum[14:0], 16'h0000});

   assign ctl_in.valid = in_valid;
   assign ctl_in.kept  = (beam_range >= range_floor) && (beam_range <= range_ceiling);
   assign ctl_in.done  = scan_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.kept <= ctl_in.kept;
      ctl_ff.done <= ctl_in.done;
      x_ff        <= x_in;
      z_ff        <= z_in;
   end

   assign ctl_o = ctl_ff;
   assign x_o   = x_ff;
   assign z_o   = z_ff;

endmodule

[sv/spp_cordic.sv]
// Pipelined rotation-mode CORDIC, one registered micro-rotation per stage.
// Depends on spp_pkg for the stage count, widths and arctangent table.
`timescale 1ns / 1ps

module spp_cordic import spp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  spp_ctl_type          ctl_i,
   input  logic signed [XW-1:0] x_i,
   input  logic signed [ZW-1:0] z_i,
   output spp_ctl_type          ctl_o,
   output logic signed [XW-1:0] x_o,
   output logic signed [XW-1:0] y_o
);

   spp_ctl_type          ctl_ff [CORDIC_RUN];
   logic signed [XW-1:0] x_ff   [CORDIC_RUN];
   logic signed [XW-1:0] y_ff   [CORDIC_RUN];
   logic signed [ZW-1:0] z_ff   [CORDIC_RUN];

   for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN = spp_atan(i);
      spp_ctl_type          ctl_src;
      logic signed [XW-1:0] x_src, y_src, dx, dy, x_in, y_in;
      logic signed [ZW-1:0] z_src, z_in;

      if (i == 0) begin : g_first
         assign ctl_src = ctl_i;
         assign x_src   = x_i;
         assign y_src   = '0;
         assign z_src   = z_i;
      end else begin : g_next
         assign ctl_src = ctl_ff[i-1];
         assign x_src   = x_ff[i-1];
         assign y_src   = y_ff[i-1];
         assign z_src   = z_ff[i-1];
      end

      assign dx = y_src >>> i;
      assign dy = x_src >>> i;

      // A residual of zero rotates in the positive direction.
      always_comb begin
         if (!z_src[ZW-1]) begin
            x_in = x_src - dx;
            y_in = y_src + dy;
            z_in = z_src - ATAN;
         end else begin
            x_in = x_src + dx;
            y_in = y_src - dy;
            z_in = z_src + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i].valid <= 1'b0;
         end else begin
            ctl_ff[i].valid <= ctl_src.valid;
         end
         ctl_ff[i].kept <= ctl_src.kept;
         ctl_ff[i].done <= ctl_src.done;
         x_ff[i]        <= x_in;
         y_ff[i]        <= y_in;
         z_ff[i]        <= z_in;
      end
   end

   assign ctl_o = ctl_ff[CORDIC_RUN-1];
   assign x_o   = x_ff[CORDIC_RUN-1];
   assign y_o   = y_ff[CORDIC_RUN-1];

endmodule

[sv/spp_output.sv]
// Output stages: rounding to whole millimetres, then pose offset and saturation.
// Depends on spp_pkg for widths, rounding constant and the control struct.
`timescale 1ns / 1ps

module spp_output import spp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  spp_ctl_type          ctl_i,
   input  logic signed [XW-1:0] x_i,
   input  logic signed [XW-1:0] y_i,
   input  logic signed [31:0]   pose_x,
   input  logic signed [31:0]   pose_y,
   output logic                 rsp_strobe,
   output logic signed [31:0]   rsp_point_x,
   output logic signed [31:0]   rsp_point_y,
   output logic                 rsp_point_kept,
   output logic                 rsp_scan_done
);

   function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
      logic signed [31:0] res;
      if (v[SW-1:31] == '0 || v[SW-1:31] == '1) begin
         res = v[31:0];
      end else if (v[SW-1]) begin
         res = 32'sh80000000;
      end else begin
         res = 32'sh7FFFFFFF;
      end
      return res;
   endfunction

   spp_ctl_type          ctl_r_ff;
   logic signed [RW-1:0] xr_ff, xr_in, yr_ff, yr_in;
   logic signed [XW-1:0] x_round, y_round;
   logic signed [SW-1:0] x_sum, y_sum;

   logic                 strobe_ff, strobe_in;
   logic signed [31:0]   px_ff, px_in, py_ff, py_in;
   logic                 kept_ff, kept_in, done_ff, done_in;

   assign x_round = x_i + ROUND_HALF;
   assign y_round = y_i + ROUND_HALF;
   assign xr_in   = $signed(x_round[XW-1:FRAC]);
   assign yr_in   = $signed(y_round[XW-1:FRAC]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_r_ff.valid <= 1'b0;
      end else begin
         ctl_r_ff.valid <= ctl_i.valid;
      end
      ctl_r_ff.kept <= ctl_i.kept;
      ctl_r_ff.done <= ctl_i.done;
      xr_ff         <= xr_in;
      yr_ff         <= yr_in;
   end

   assign x_sum = SW'(xr_ff) + SW'(pose_x);
   assign y_sum = SW'(yr_ff) + SW'(pose_y);

   // A dropped return reports zero coordinates.
   assign strobe_in = ctl_r_ff.valid;
   assign kept_in   = ctl_r_ff.kept;
   assign done_in   = ctl_r_ff.done;
   assign px_in     = ctl_r_ff.kept ? sat32(x_sum) : '0;
   assign py_in     = ctl_r_ff.kept ? sat32(y_sum) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      kept_ff <= kept_in;
      done_ff <= done_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_point_x    = px_ff;
   assign rsp_point_y    = py_ff;
   assign rsp_point_kept = kept_ff;
   assign rsp_scan_done  = done_ff;

endmodule

[sv/scan_point_projection_top.sv]
// Top level of the scan point projection: registers, front stage, CORDIC, output.
// Depends on spp_pkg, spp_csr, spp_front, spp_cordic and spp_output.
//
//   channel   handshake                      payload
//   request   start / busy                   req_beam_range, req_beam_angle, req_scan_end
//   result    rsp_strobe (one cycle)         rsp_point_x, rsp_point_y, rsp_point_kept,
//                                            rsp_scan_done
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One return is taken every cycle while busy is low; its result strobes once it has
// passed the front stage, one register per CORDIC stage, the rounding stage and the
// offset/saturation stage. The result is not held off by the receiver, so the
// pipeline never stalls. busy is a registered copy of reset; synchronous reset
// empties the pipeline and restores registers.
`timescale 1ns / 1ps

module scan_point_projection_top import spp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_beam_range,
   input  logic [15:0]        req_beam_angle,
   input  logic               req_scan_end,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_point_kept,
   output logic               rsp_scan_done,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [AW-1:0]      paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic                 busy_ff, busy_in;
   logic signed [31:0]   pose_x, pose_y;
   logic [15:0]          pose_heading, range_floor, range_ceiling;
   spp_ctl_type          front_ctl, cordic_ctl;
   logic signed [XW-1:0] front_x, cordic_x, cordic_y;
   logic signed [ZW-1:0] front_z;

   assign busy_in = reset;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy = busy_ff;

   spp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .pose_x        (pose_x),
      .pose_y        (pose_y),
      .pose_heading  (pose_heading),
      .range_floor   (range_floor),
      .range_ceiling (range_ceiling)
   );

   spp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy_ff),
      .beam_range    (req_beam_range),
      .beam_angle    (req_beam_angle),
      .scan_end      (req_scan_end),
      .pose_heading  (pose_heading),
      .range_floor   (range_floor),
      .range_ceiling (range_ceiling),
      .ctl_o         (front_ctl),
      .x_o           (front_x),
      .z_o           (front_z)
   );

   spp_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .ctl_i (front_ctl),
      .x_i   (front_x),
      .z_i   (front_z),
      .ctl_o (cordic_ctl),
      .x_o   (cordic_x),
      .y_o   (cordic_y)
   );

   spp_output u_output (
      .clock          (clock),
      .reset          (reset),
      .ctl_i          (cordic_ctl),
      .x_i            (cordic_x),
      .y_i            (cordic_y),
      .pose_x         (pose_x),
      .pose_y         (pose_y),
      .rsp_strobe     (rsp_strobe),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_kept (rsp_point_kept),
      .rsp_scan_done  (rsp_scan_done)
   );

endmodule

[sv/spp_checker.sv]
// Port-level checker for the scan point projection, bound to the top level.
// Depends on spp_pkg for the latency and on the assertion macro header.
`timescale 1ns / 1ps
`include "scan_point_projection_top_assert.svh"

module spp_checker import spp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [15:0]        req_beam_range,
   input logic [15:0]        req_beam_angle,
   input logic               req_scan_end,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_point_x,
   input logic signed [31:0] rsp_point_y,
   input logic               rsp_point_kept,
   input logic               rsp_scan_done,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [AW-1:0]      paddr,
   input logic [31:0]        pwdata,
   input logic [31:0]        prdata,
   input logic               pready
);

   logic accepted;

   assign accepted = start && !busy;

   // Every accepted beat must be followed by its result strobe.
   `SPP_ASSERT_DELAY(a_result_follows, accepted, LATENCY, rsp_strobe, "result beat missing")

   // No result beat appears without a matching beat accepted earlier.
   `SPP_ASSERT_NOW(a_no_spurious, rsp_strobe, $past(accepted, LATENCY), "spurious result beat")

   `SPP_ASSERT_NOW(a_scan_done, rsp_strobe, rsp_scan_done == $past(req_scan_end, LATENCY),
      "scan_done does not match its request")

   `SPP_ASSERT_NOW(a_dropped_zero, rsp_strobe && !rsp_point_kept,
      rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0, "dropped return has nonzero point")

endmodule

bind scan_point_projection_top spp_checker u_checker (.*);

[dv/scan_point_projection_top_tb.sv]
// Self-checking testbench for scan_point_projection_top: drives lidar returns and
// register writes, predicts every projected point and compares it field by field.
// Depends on spp_pkg and the RTL of the scan point projection block.
`timescale 1ns / 1ps

module scan_point_projection_top_tb import spp_pkg::*; ();

   typedef struct packed {
      logic [15:0] beam_range;
      logic [15:0] beam_angle;
      logic        scan_end;
   } beam_return_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               point_kept;
      logic               scan_done;
   } scan_point_type;

   localparam longint INV_GAIN_Q30 = 652032875;

   // Rotation angle of each stage, 2^32 counts per turn.
   localparam logic signed [31:0] STAGE_ANGLE [0:23] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [15:0]        req_beam_range = '0;
   logic [15:0]        req_beam_angle = '0;
   logic               req_scan_end = 1'b0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic               rsp_point_kept;
   logic               rsp_scan_done;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [AW-1:0]      paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // Register shadow used by the predictor.
   logic signed [31:0] pose_x_mm = '0;
   logic signed [31:0] pose_y_mm = '0;
   logic [15:0]        heading_cnt = '0;
   logic [15:0]        range_floor_mm = '0;
   logic [15:0]        range_ceiling_mm = 16'hFFFF;

   beam_return_type pending_returns[$];
   scan_point_type  expected_points[$];
   beam_return_type beat_on_bus;
   int           burst_left = 1;
   int           gap_left = 0;
   bit           steady_feed = 1'b0;
   int           error_count = 0;
   int           accepted_count = 0;
   int           kept_count = 0;
   int           dropped_count = 0;
   int           pose_count = 0;

   scan_point_projection_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_beam_range (req_beam_range),
      .req_beam_angle (req_beam_angle),
      .req_scan_end   (req_scan_end),
      .rsp_strobe     (rsp_strobe),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_kept (rsp_point_kept),
      .rsp_scan_done  (rsp_scan_done),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp_mm(input longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648)
         return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic scan_point_type project_return(input beam_return_type b);
      scan_point_type     p;
      logic [15:0]        turn;
      logic signed [31:0] z32;
      longint             x, y, z, t, dx, dy;
      p.scan_done  = b.scan_end;
      p.point_x    = '0;
      p.point_y    = '0;
      p.point_kept = 1'b0;
      if (b.beam_range < range_floor_mm || b.beam_range > range_ceiling_mm)
         return p;
      turn = b.beam_angle + heading_cnt;
      z32  = {turn, 16'h0000};
      z    = longint'(z32);
      x    = longint'(b.beam_range);
      x    = x * INV_GAIN_Q30;
      y    = 0;
      // Fold angles beyond a quarter turn back by a half turn and flip the vector.
      if (z > 64'sd1073741824) begin
         x = -x;
         z = z - 64'sd2147483648;
      end else if (z < -64'sd1073741824) begin
         x = -x;
         z = z + 64'sd2147483648;
      end
      for (int i = 0; i < CORDIC_RUN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            t = x - dx;
            y = y + dy;
            z = z - longint'(STAGE_ANGLE[i]);
         end else begin
            t = x + dx;
            y = y - dy;
            z = z + longint'(STAGE_ANGLE[i]);
         end
         x = t;
      end
      x = (x + (64'sd1 <<< 29)) >>> 30;
      y = (y + (64'sd1 <<< 29)) >>> 30;
      p.point_x    = clamp_mm(x + longint'(pose_x_mm));
      p.point_y    = clamp_mm(y + longint'(pose_y_mm));
      p.point_kept = 1'b1;
      return p;
   endfunction

   // Driver: sends returns in bursts with random gaps in between, gapless under steady feed.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_points.insert(expected_points.size(), project_return(beat_on_bus));
            accepted_count++;
         end
         if (start && busy) begin
            // Beat not taken yet; hold it.
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left  = gap_left - 1;
         end else if (pending_returns.size() > 0) begin
            beat_on_bus     = pending_returns.pop_front();
            start          <= 1'b1;
            req_beam_range <= beat_on_bus.beam_range;
            req_beam_angle <= beat_on_bus.beam_angle;
            req_scan_end   <= beat_on_bus.scan_end;
            burst_left      = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               if (steady_feed || $urandom_range(0, 3) == 0)
                  gap_left = 0;
               else
                  gap_left = $urandom_range(1, 6);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      scan_point_type want;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d kept=%0b done=%0b", $time,
                     rsp_point_x, rsp_point_y, rsp_point_kept, rsp_scan_done);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_point_x !== want.point_x) begin
               $display("%0t: point_x expected %0d actual %0d", $time, want.point_x,
                        rsp_point_x);
               error_count++;
            end
            if (rsp_point_y !== want.point_y) begin
               $display("%0t: point_y expected %0d actual %0d", $time, want.point_y,
                        rsp_point_y);
               error_count++;
            end
            if (rsp_point_kept !== want.point_kept) begin
               $display("%0t: point_kept expected %0b actual %0b", $time,
                        want.point_kept, rsp_point_kept);
               error_count++;
            end
            if (rsp_scan_done !== want.scan_done) begin
               $display("%0t: scan_done expected %0b actual %0b", $time,
                        want.scan_done, rsp_scan_done);
               error_count++;
            end
            if (want.point_kept)
               kept_count++;
            else
               dropped_count++;
         end
      end
   end

   task automatic queue_return(input beam_return_type b);
      pending_returns.insert(pending_returns.size(), b);
   endtask

   task automatic wait_for_drain();
      while (pending_returns.size() != 0 || start || expected_points.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_POSE_X:        pose_x_mm        = value;
         REG_POSE_Y:        pose_y_mm        = value;
         REG_POSE_HEADING:  heading_cnt      = value[15:0];
         REG_RANGE_FLOOR:   range_floor_mm   = value[15:0];
         REG_RANGE_CEILING: range_ceiling_mm = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_pose(input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] heading, input logic [15:0] floor_mm,
                            input logic [15:0] ceiling_mm);
      wait_for_drain();
      write_register(REG_POSE_X, x);
      write_register(REG_POSE_Y, y);
      write_register(REG_POSE_HEADING, {16'h0, heading});
      write_register(REG_RANGE_FLOOR, {16'h0, floor_mm});
      write_register(REG_RANGE_CEILING, {16'h0, ceiling_mm});
      pose_count++;
   endtask

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFFFFFF;
         1:       return 32'h80000000;
         2:       return $urandom;
         default: return $urandom_range(0, 200000) - 100000;
      endcase
   endfunction

   function automatic beam_return_type random_return();
      beam_return_type b;
      case ($urandom_range(0, 7))
         0:       b.beam_range = 16'(range_floor_mm - $urandom_range(0, 1));
         1:       b.beam_range = 16'(range_ceiling_mm + $urandom_range(0, 1));
         2:       b.beam_range = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: b.beam_range = 16'($urandom);
      endcase
      // Some beams land at or next to a multiple of a quarter turn after the heading, the fold points among them.
      if ($urandom_range(0, 4) == 0)
         b.beam_angle = 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1
                            - heading_cnt);
      else
         b.beam_angle = 16'($urandom);
      b.scan_end = ($urandom_range(0, 15) == 0);
      return b;
   endfunction

   initial begin
      logic [15:0]     lo, hi;
      beam_return_type b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy)
         @(posedge clock);

      // Reset settings: full window, no pose; extremes of range and angle.
      queue_return('{16'd0, 16'h0000, 1'b0});
      queue_return('{16'hFFFF, 16'h0000, 1'b0});
      queue_return('{16'hFFFF, 16'h3FFF, 1'b0});
      queue_return('{16'hFFFF, 16'h4000, 1'b1});
      queue_return('{16'hFFFF, 16'h4001, 1'b0});
      queue_return('{16'hFFFF, 16'h8000, 1'b0});
      queue_return('{16'hFFFF, 16'hBFFF, 1'b0});
      queue_return('{16'hFFFF, 16'hC000, 1'b0});
      queue_return('{16'hFFFF, 16'hC001, 1'b0});
      queue_return('{16'hFFFF, 16'hFFFF, 1'b1});
      queue_return('{16'd1000, 16'h2000, 1'b0});

      // Window edges and saturation against extreme offsets.
      load_pose(32'h7FFFFFFF, 32'h80000000, 16'h4000, 16'd100, 16'd200);
      queue_return('{16'd99, 16'h0000, 1'b0});
      queue_return('{16'd100, 16'h0000, 1'b0});
      queue_return('{16'd200, 16'h8000, 1'b1});
      queue_return('{16'd201, 16'h0000, 1'b0});
      queue_return('{16'd150, 16'hC000, 1'b0});
      queue_return('{16'd150, 16'h4000, 1'b0});
      load_pose(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      queue_return('{16'hFFFF, 16'h8001, 1'b0});
      queue_return('{16'hFFFF, 16'h4001, 1'b1});

      // Inverted window drops every return.
      load_pose(32'd0, 32'd0, 16'd0, 16'd500, 16'd400);
      queue_return('{16'd450, 16'h1234, 1'b0});
      queue_return('{16'd400, 16'h0000, 1'b0});
      queue_return('{16'd500, 16'h0000, 1'b1});

      for (int phase = 0; phase < 8; phase++) begin
         lo = 16'($urandom);
         hi = 16'($urandom);
         case ($urandom_range(0, 4))
            0: begin
               lo = 16'h0000;
               hi = 16'hFFFF;
            end
            1: if (lo > hi) {lo, hi} = {hi, lo};
            2: if (lo < hi) {lo, hi} = {hi, lo};
            3: hi = lo;
            default: begin
               lo = 16'($urandom_range(0, 2000));
               hi = 16'($urandom_range(30000, 65535));
            end
         endcase
         load_pose(pick_offset(), pick_offset(), 16'($urandom), lo, hi);
         steady_feed = (phase == 7);
         for (int n = 0; n < 115; n++) begin
            b = random_return();
            queue_return(b);
            // Hold the feed once mid-phase until all results are back.
            if (phase == 3 && n == 57)
               wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (LATENCY + 8) @(posedge clock);
      if (expected_points.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_points.size());
         error_count++;
      end
      $display("Projected %0d returns (%0d kept, %0d dropped) over %0d pose settings.",
               accepted_count, kept_count, dropped_count, pose_count + 1);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2ms;
      $display("Timeout with %0d results outstanding.", expected_points.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
